/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the reverb chain.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define SRV_ASSERT(label, ck, rn, prop) \
  label: assert property (@(posedge ck) disable iff (!(rn)) prop) \
    else $error("srv_checker: property failed");

// Concurrent assertion that is also checked while reset is asserted.
`define SRV_ASSERT_ALWAYS(label, ck, prop) \
  label: assert property (@(posedge ck) prop) \
    else $error("srv_checker: property failed");

`endif

/* rtl/core/srv_pkg.sv */
// Package of types, constants and arithmetic helpers for the reverb chain.
`timescale 1ns / 1ps

package srv_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int GAIN_W        = 15;
  localparam int PROD_W        = 32;
  localparam int QUOT_W        = 17;
  localparam int SUM_W         = 18;
  localparam int COMB_COUNT    = 4;
  localparam int ALLPASS_COUNT = 2;
  localparam int STAGE_COUNT   = COMB_COUNT + ALLPASS_COUNT;
  localparam int GAIN_COUNT    = COMB_COUNT + ALLPASS_COUNT;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = $clog2(GAIN_COUNT * 4);
  localparam int CFG_IDX_W     = CFG_ADDR_W - 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [GAIN_W-1:0]   gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  // Delay line lengths in samples. Each must exceed the depth of its stage.
  localparam int COMB_DELAY    [COMB_COUNT]    = '{1309, 1636, 1812, 1927};
  localparam int ALLPASS_DELAY [ALLPASS_COUNT] = '{220, 74};

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_COMB_GAIN_FIRST     = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_COMB_GAIN_SECOND    = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_COMB_GAIN_THIRD     = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_COMB_GAIN_FOURTH    = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_ALLPASS_GAIN_FIRST  = cfg_idx_t'(4);
  localparam cfg_idx_t CFG_ALLPASS_GAIN_SECOND = cfg_idx_t'(5);

  localparam gain_t GAIN_RESET [GAIN_COUNT] = '{
    gain_t'(26378), gain_t'(27099), gain_t'(25657),
    gain_t'(25035), gain_t'(22938), gain_t'(22938)
  };

  localparam int   SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int   SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
  localparam prod_t GAIN_ROUND = prod_t'((1 << GAIN_W) - 1);

  // Q0.15 gain times a sample, full precision.
  function automatic prod_t gain_mul(gain_t g, sample_t s);
    return prod_t'($signed({1'b0, g})) * prod_t'(s);
  endfunction

  // Drop the 15 fraction bits, rounding toward zero.
  function automatic quot_t gain_quot(prod_t p);
    prod_t biased;
    biased = p + (p[PROD_W-1] ? GAIN_ROUND : prod_t'(0));
    return biased[PROD_W-1:GAIN_W];
  endfunction

  // Clamp a sum to the signed 16-bit sample range.
  function automatic sample_t sat16(sum_t v);
    if (v > sum_t'(SAMPLE_MAX)) begin
      return sample_t'(SAMPLE_MAX);
    end else if (v < sum_t'(SAMPLE_MIN)) begin
      return sample_t'(SAMPLE_MIN);
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

/* rtl/core/srv_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module srv_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/schroeder_reverb_chain.sv */
// Top level of the Schroeder reverb chain: four series combs and two all-pass stages.
`timescale 1ns / 1ps
//
// Usage. One signed 16-bit sample enters per transfer on the in_ channel
// (in_valid, in_ready, in_sample_in) and one reverberated sample leaves per
// transfer on the out_ channel (out_valid, out_ready, out_sample_out).
// The sample runs through four feedback comb stages and two all-pass stages.
// Each comb stage registers its delay line read, the gain product, and the
// saturated sum that it writes back; each all-pass stage registers the reads
// of its two lines, both gain products, the feedback sum, and its written-back output.
// Throughput is one sample per cycle while the pipeline is not held; the delay
// line RAMs, each with one read and one write port, are touched once per sample.
// A two-entry output buffer parts the pipeline from the receiver: while one
// result waits, new samples are still taken. When both entries are full and
// out_ready is low, the whole pipeline holds and in_ready drops; nothing is
// lost or repeated.
// Gains are written over the APB-style port (byte address 4*i for register
// i, in the access phase); the user must write them only while the chain is idle,
// as the block does not enforce it. Reset is synchronous and active low. It
// clears all valid bits, the line positions and the output buffer, and restores
// the gain defaults. The delay line RAMs are not swept: each line carries a fill
// flag, and until its position first wraps every read from it counts as zero.

module schroeder_reverb_chain import srv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_sample_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [1:0] OBUF_FULL = 2'd2;

  // Gain registers.
  gain_t    gain_r [GAIN_COUNT];
  cfg_idx_t cfg_idx;
  logic     cfg_wr;

  // Registered outputs of each stage.
  logic    sv_r [STAGE_COUNT];
  sample_t sx_r [STAGE_COUNT];

  // Global advance of the pipeline.
  logic en;

  // Output buffer.
  logic [1:0] ocnt_r, ocnt_nxt;
  sample_t    ob0_r, ob1_r;
  logic       push, pop;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GAIN_COUNT; i++) begin
        gain_r[i] <= GAIN_RESET[i];
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_COMB_GAIN_FIRST:     gain_r[CFG_COMB_GAIN_FIRST]     <= pwdata[GAIN_W-1:0];
        CFG_COMB_GAIN_SECOND:    gain_r[CFG_COMB_GAIN_SECOND]    <= pwdata[GAIN_W-1:0];
        CFG_COMB_GAIN_THIRD:     gain_r[CFG_COMB_GAIN_THIRD]     <= pwdata[GAIN_W-1:0];
        CFG_COMB_GAIN_FOURTH:    gain_r[CFG_COMB_GAIN_FOURTH]    <= pwdata[GAIN_W-1:0];
        CFG_ALLPASS_GAIN_FIRST:  gain_r[CFG_ALLPASS_GAIN_FIRST]  <= pwdata[GAIN_W-1:0];
        CFG_ALLPASS_GAIN_SECOND: gain_r[CFG_ALLPASS_GAIN_SECOND] <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_COMB_GAIN_FIRST:     prdata = CFG_DATA_W'(gain_r[CFG_COMB_GAIN_FIRST]);
      CFG_COMB_GAIN_SECOND:    prdata = CFG_DATA_W'(gain_r[CFG_COMB_GAIN_SECOND]);
      CFG_COMB_GAIN_THIRD:     prdata = CFG_DATA_W'(gain_r[CFG_COMB_GAIN_THIRD]);
      CFG_COMB_GAIN_FOURTH:    prdata = CFG_DATA_W'(gain_r[CFG_COMB_GAIN_FOURTH]);
      CFG_ALLPASS_GAIN_FIRST:  prdata = CFG_DATA_W'(gain_r[CFG_ALLPASS_GAIN_FIRST]);
      CFG_ALLPASS_GAIN_SECOND: prdata = CFG_DATA_W'(gain_r[CFG_ALLPASS_GAIN_SECOND]);
      default:                 prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output buffer has room or is being drained.
  assign en       = (ocnt_r != OBUF_FULL) || out_ready;
  assign in_ready = en;

  // Comb stages: y = sat(x + g*y[n-D]).
  for (genvar k = 0; k < COMB_COUNT; k++) begin : g_comb
    localparam int D  = COMB_DELAY[k];
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam logic [AW-1:0] LAST = AW'(D - 1);

    logic          vin;
    sample_t       xin;
    logic [AW-1:0] pos_r, p1_r, p2_r;
    logic          filled_r, f1_r;
    logic          v1_r, v2_r;
    sample_t       x1_r, x2_r;
    prod_t         prod_r;
    logic [SAMPLE_W-1:0] rd;
    sample_t       fb;
    sample_t       y;

    if (k == 0) begin : g_src_port
      assign vin = in_valid;
      assign xin = in_sample_in;
    end else begin : g_src_stage
      assign vin = sv_r[k-1];
      assign xin = sx_r[k-1];
    end

    // Until the line has wrapped once, its contents count as zero.
    assign fb = f1_r ? sample_t'(rd) : '0;
    assign y  = sat16(sum_t'(x2_r) + sum_t'(gain_quot(prod_r)));

    srv_ram #(.DEPTH(D), .WIDTH(SAMPLE_W)) u_line (
      .clk   (clk),
      .we    (en && v2_r),
      .waddr (p2_r),
      .wdata (y),
      .re    (en),
      .raddr (pos_r),
      .rdata (rd)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r    <= '0;
        filled_r <= 1'b0;
        v1_r     <= 1'b0;
        v2_r     <= 1'b0;
        sv_r[k]  <= 1'b0;
      end else if (en) begin
        v1_r    <= vin;
        v2_r    <= v1_r;
        sv_r[k] <= v2_r;
        if (vin) begin
          if (pos_r == LAST) begin
            pos_r    <= '0;
            filled_r <= 1'b1;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x1_r    <= xin;
        p1_r    <= pos_r;
        f1_r    <= filled_r;
        prod_r  <= gain_mul(gain_r[k], fb);
        x2_r    <= x1_r;
        p2_r    <= p1_r;
        sx_r[k] <= y;
      end
    end
  end

  // All-pass stages: t = sat(x + g*y[n-D]), y = sat(t - g*x[n-D]).
  for (genvar j = 0; j < ALLPASS_COUNT; j++) begin : g_allpass
    localparam int S  = COMB_COUNT + j;
    localparam int D  = ALLPASS_DELAY[j];
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam logic [AW-1:0] LAST = AW'(D - 1);

    logic          vin;
    sample_t       xin;
    logic [AW-1:0] pos_r, p1_r, p2_r, p3_r;
    logic          filled_r, f1_r;
    logic          v1_r, v2_r, v3_r;
    sample_t       x1_r, x2_r, x3_r;
    prod_t         prod_out_r, prod_in_r;
    sample_t       t_r;
    quot_t         q_in_r;
    logic [SAMPLE_W-1:0] rd_out, rd_in;
    sample_t       fb_out, fb_in;
    sample_t       t;
    sample_t       y;

    assign vin = sv_r[S-1];
    assign xin = sx_r[S-1];

    assign fb_out = f1_r ? sample_t'(rd_out) : '0;
    assign fb_in  = f1_r ? sample_t'(rd_in)  : '0;
    assign t      = sat16(sum_t'(x2_r) + sum_t'(gain_quot(prod_out_r)));
    assign y      = sat16(sum_t'(t_r) - sum_t'(q_in_r));

    srv_ram #(.DEPTH(D), .WIDTH(SAMPLE_W)) u_out_line (
      .clk   (clk),
      .we    (en && v3_r),
      .waddr (p3_r),
      .wdata (y),
      .re    (en),
      .raddr (pos_r),
      .rdata (rd_out)
    );

    srv_ram #(.DEPTH(D), .WIDTH(SAMPLE_W)) u_in_line (
      .clk   (clk),
      .we    (en && v3_r),
      .waddr (p3_r),
      .wdata (x3_r),
      .re    (en),
      .raddr (pos_r),
      .rdata (rd_in)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r    <= '0;
        filled_r <= 1'b0;
        v1_r     <= 1'b0;
        v2_r     <= 1'b0;
        v3_r     <= 1'b0;
        sv_r[S]  <= 1'b0;
      end else if (en) begin
        v1_r    <= vin;
        v2_r    <= v1_r;
        v3_r    <= v2_r;
        sv_r[S] <= v3_r;
        if (vin) begin
          if (pos_r == LAST) begin
            pos_r    <= '0;
            filled_r <= 1'b1;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x1_r       <= xin;
        p1_r       <= pos_r;
        f1_r       <= filled_r;
        prod_out_r <= gain_mul(gain_r[S], fb_out);
        prod_in_r  <= gain_mul(gain_r[S], fb_in);
        x2_r       <= x1_r;
        p2_r       <= p1_r;
        t_r        <= t;
        q_in_r     <= gain_quot(prod_in_r);
        x3_r       <= x2_r;
        p3_r       <= p2_r;
        sx_r[S]    <= y;
      end
    end
  end

  // Output buffer, two entries deep; entry zero is the head.
  assign push      = en && sv_r[STAGE_COUNT-1];
  assign out_valid = (ocnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_sample_out = ob0_r;

  always_comb begin
    ocnt_nxt = ocnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else begin
      ocnt_r <= ocnt_nxt;
    end
  end

  // A new result lands in the head when the buffer is empty after any pop.
  always_ff @(posedge clk) begin
    if (push && ((ocnt_r - 2'(pop)) == 2'd0)) begin
      ob0_r <= sx_r[STAGE_COUNT-1];
    end else if (pop) begin
      ob0_r <= ob1_r;
    end
    if (push && ((ocnt_r - 2'(pop)) != 2'd0)) begin
      ob1_r <= sx_r[STAGE_COUNT-1];
    end
  end

endmodule

/* rtl/core/srv_checker.sv */
// Port-level checker of the reverb chain and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample_out
);

  // A stalled result stays offered and unchanged.
  `SRV_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sample_out))

  // Input is refused only while a result waits and the receiver stalls.
  `SRV_ASSERT(a_refuse_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready)

  // A full output buffer cannot empty without a transfer.
  `SRV_ASSERT(a_full_persists, clk, rst_n, !in_ready |=> out_valid)

  // Reset empties the output buffer.
  `SRV_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind schroeder_reverb_chain srv_checker u_srv_checker (.*);

/* bench/tb.sv */
// Self-checking testbench for the Schroeder reverb chain: sample predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb;
  import srv_pkg::*;

  // A stalled transfer can wait out one receiver stall plus the full pipeline,
  // so a quiet stretch this long means the chain has hung.
  localparam int QUIET_LIMIT = 2000;
  // Final wait that outlasts the pipeline from input to output, with margin.
  localparam int DRAIN_CYCLES = 32;
  // Register indexes that decode to nothing; writes there must change no gain.
  localparam cfg_idx_t CFG_SPARE_FIRST  = cfg_idx_t'(6);
  localparam cfg_idx_t CFG_SPARE_SECOND = cfg_idx_t'(7);

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  sample_t               in_sample_in;
  logic                  out_valid;
  logic                  out_ready;
  sample_t               out_sample_out;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: one history line per comb, two per all-pass, and their positions.
  // The lines are sized for the largest depth that the positions can address.
  sample_t comb_hist   [COMB_COUNT][2048];
  sample_t ap_out_hist [ALLPASS_COUNT][256];
  sample_t ap_in_hist  [ALLPASS_COUNT][256];
  int      comb_pos    [COMB_COUNT];
  int      ap_pos      [ALLPASS_COUNT];
  gain_t   gain_model  [GAIN_COUNT];

  // Reverberated samples that the chain still owes, oldest first.
  sample_t pending_out [$];

  int error_count;
  int quiet_cycles;
  int stall_left;
  bit idle_on;

  schroeder_reverb_chain u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q0.15 gain times a sample. SystemVerilog integer division truncates toward
  // zero, which is exactly the rounding the chain must apply to negative products.
  function automatic int scale_by_gain(gain_t g, int v);
    int prod;
    prod = int'(g) * v;
    return prod / 32768;
  endfunction

  function automatic int clamp16(int v);
    if (v > SAMPLE_MAX) begin
      return SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      return SAMPLE_MIN;
    end
    return v;
  endfunction

  // Runs one sample through the four series combs and the two all-pass stages,
  // updating the history lines the same way the chain does.
  function automatic sample_t reverb_predict(sample_t s);
    int x;
    int t;
    int p;
    x = s;
    for (int k = 0; k < COMB_COUNT; k++) begin
      p = comb_pos[k];
      x = clamp16(x + scale_by_gain(gain_model[k], comb_hist[k][p]));
      comb_hist[k][p] = sample_t'(x);
      comb_pos[k] = (p + 1 >= COMB_DELAY[k]) ? 0 : p + 1;
    end
    for (int k = 0; k < ALLPASS_COUNT; k++) begin
      p = ap_pos[k];
      // The feedback sum saturates first, then the feed-forward term is
      // subtracted and the result saturates again.
      t = clamp16(x + scale_by_gain(gain_model[COMB_COUNT + k], ap_out_hist[k][p]));
      t = clamp16(t - scale_by_gain(gain_model[COMB_COUNT + k], ap_in_hist[k][p]));
      ap_out_hist[k][p] = sample_t'(t);
      ap_in_hist[k][p] = sample_t'(x);
      ap_pos[k] = (p + 1 >= ALLPASS_DELAY[k]) ? 0 : p + 1;
      x = t;
    end
    return sample_t'(x);
  endfunction

  // Mostly full-scale noise, with quiet passages, rail values and silence mixed in
  // so that both decaying tails and saturation get exercised.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return sample_t'($urandom);
      5, 6:          return sample_t'(int'($urandom_range(0, 511)) - 256);
      7:             return $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
      default:       return sample_t'(0);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Offers one sample and waits for its transfer. When idling is enabled the sender
  // sometimes drops valid for a short burst first. Valid is never lowered on exit,
  // so back-to-back calls stream one sample per cycle while in_ready is high.
  task automatic send_sample(input sample_t s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      in_sample_in <= sample_t'($urandom);
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_out.push_back(reverb_predict(s));
  endtask

  // Stops the sender and waits until every owed sample has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  // One APB write: a setup phase, an access phase, then an idle phase so that
  // back-to-back accesses never assign psel twice in one time step.
  task automatic write_gain(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // Only the low 15 bits are kept, and spare indexes are ignored.
    if (idx < GAIN_COUNT) begin
      gain_model[idx] = data[GAIN_W-1:0];
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_gain(input cfg_idx_t idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(gain_model[idx])) begin
      report_mismatch($sformatf("gain register %0d", idx), int'(prdata), int'(gain_model[idx]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all six gains with random junk above bit 14, which must be dropped.
  task automatic set_gains(input gain_t gains [GAIN_COUNT]);
    for (int k = 0; k < GAIN_COUNT; k++) begin
      write_gain(cfg_idx_t'(k), {17'($urandom), gains[k]});
    end
  endtask

  // Random stream with an occasional impulse followed by silence, so the comb
  // and all-pass tails ring out on their own.
  task automatic stream_samples(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 49) == 0) begin
        send_sample($urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN));
        repeat (20) send_sample(sample_t'(0));
        sent += 21;
      end else begin
        send_sample(random_sample());
        sent++;
      end
    end
  endtask

  // The gains must come out of reset at their documented defaults.
  task automatic test_reset_defaults();
    for (int k = 0; k < GAIN_COUNT; k++) begin
      check_gain(cfg_idx_t'(k));
    end
  endtask

  // Rail values, sign patterns and silence while every line is still empty,
  // so the delayed terms contribute nothing yet.
  task automatic test_edge_samples();
    sample_t edge_values [$];
    edge_values = '{sample_t'(0), sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN),
                    sample_t'(-1), sample_t'(1), sample_t'(16'h5555), sample_t'(16'hAAAA)};
    repeat (6) edge_values.push_back(sample_t'(SAMPLE_MAX));
    repeat (6) edge_values.push_back(sample_t'(SAMPLE_MIN));
    repeat (3) edge_values.push_back(sample_t'(0));
    foreach (edge_values[i]) begin
      send_sample(edge_values[i]);
    end
    drain_results();
  endtask

  // Every register is written with all ones and with only bits 15 to 31 set,
  // read back each time, and the spare indexes must leave every gain untouched.
  task automatic test_gain_registers();
    for (int k = 0; k < GAIN_COUNT; k++) begin
      write_gain(cfg_idx_t'(k), 32'hFFFF_FFFF);
      check_gain(cfg_idx_t'(k));
      write_gain(cfg_idx_t'(k), 32'hFFFF_8000);
      check_gain(cfg_idx_t'(k));
    end
    write_gain(CFG_SPARE_FIRST, 32'h0000_1234);
    write_gain(CFG_SPARE_SECOND, 32'h0000_7FFF);
    for (int k = 0; k < GAIN_COUNT; k++) begin
      check_gain(cfg_idx_t'(k));
    end
  endtask

  // All gains are zero here, so the chain should pass samples straight through.
  task automatic test_zero_gain_stream();
    stream_samples(150);
    drain_results();
  endtask

  // Full-scale gains keep the lines near the rails, which drives both
  // saturation points of every stage.
  task automatic test_saturation_stream();
    gain_t gains [GAIN_COUNT];
    foreach (gains[k]) gains[k] = gain_t'(SAMPLE_MAX);
    set_gains(gains);
    stream_samples(200);
    drain_results();
  endtask

  // Mixed gains, each either an extreme or random. Midway the sender holds
  // off until every owed sample has come back, then resumes.
  task automatic test_random_gains();
    gain_t gains [GAIN_COUNT];
    foreach (gains[k]) begin
      case ($urandom_range(0, 3))
        0:       gains[k] = gain_t'(0);
        1:       gains[k] = gain_t'(SAMPLE_MAX);
        default: gains[k] = gain_t'($urandom);
      endcase
    end
    set_gains(gains);
    stream_samples(150);
    drain_results();
    stream_samples(150);
    drain_results();
  endtask

  // Back to the default gains with both sides running flat out. By now both
  // all-pass lines have wrapped, so their feedback paths read real history.
  task automatic test_calm_stream();
    set_gains(GAIN_RESET);
    for (int k = 0; k < GAIN_COUNT; k++) begin
      check_gain(cfg_idx_t'(k));
    end
    idle_on = 1'b0;
    stream_samples(300);
    drain_results();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample_in <= sample_t'(0);
    out_ready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_on = 1'b0;
    error_count = 0;

    // The predictor starts from empty lines and the default gains.
    foreach (comb_hist[k, i]) comb_hist[k][i] = sample_t'(0);
    foreach (ap_out_hist[k, i]) begin
      ap_out_hist[k][i] = sample_t'(0);
      ap_in_hist[k][i] = sample_t'(0);
    end
    foreach (comb_pos[k]) comb_pos[k] = 0;
    foreach (ap_pos[k]) ap_pos[k] = 0;
    foreach (gain_model[k]) gain_model[k] = GAIN_RESET[k];

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    idle_on = 1'b1;
    test_edge_samples();
    test_gain_registers();
    test_zero_gain_stream();
    test_saturation_stream();
    test_random_gains();
    test_calm_stream();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: holds out_ready low for random bursts while idling is enabled,
  // and accepts every cycle otherwise.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial stall_left = 0;

  // Each result transfer is compared against the oldest owed sample.
  always @(posedge clk) begin : check_results
    sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        report_mismatch("unexpected sample_out", int'(out_sample_out), 0);
      end else begin
        want = pending_out.pop_front();
        if (out_sample_out !== want) begin
          report_mismatch("sample_out", int'(out_sample_out), int'(want));
        end
      end
    end
  end

  // Any transfer on either channel or the register port counts as progress.
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/srv_pkg.sv
rtl/core/srv_ram.sv
rtl/core/schroeder_reverb_chain.sv
rtl/core/srv_checker.sv
bench/tb.sv
